FILE: rtl/core/gfc_pkg.sv
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared constants and types for the pairwise 2D gravity force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gfc_pkg;

    localparam int CHUNK_BITS     = 16;
    localparam int SQRT_FRAC_BITS = 16;
    localparam int OUT_BITS       = 48;
    localparam int GAIN_BITS      = 32;
    localparam int SHIFT_BITS     = 6;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = GAIN_BITS'(1);
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = '0;

    localparam logic [OUT_BITS-1:0] OUT_MAX_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] OUT_MAX_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GAIN  = 1'b0,
        REG_SHIFT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic vld;
        logic neg_x;
        logic neg_y;
        logic coinc;
    } side_t;

endpackage

`default_nettype wire

FILE: rtl/core/gfc_delay.sv
// ----------------------------------------------------------------------------
// gfc_delay
// Fixed-depth register line with a shared advance enable.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/core/gfc_mul.sv
// ----------------------------------------------------------------------------
// gfc_mul
// Pipelined unsigned multiplier: one 16-bit slice of b per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic      [AW+BW-1:0] p
);

    localparam int CW  = gfc_pkg::CHUNK_BITS;
    localparam int L   = (BW + CW - 1) / CW;
    localparam int BPW = L * CW;
    localparam int PW  = AW + BW;
    localparam int PPW = AW + CW;

    logic [AW-1:0]  a_reg   [L];
    logic [BPW-1:0] b_reg   [L];
    logic [PW-1:0]  acc_reg [L];
    logic [BPW-1:0] b_pad;

    assign b_pad = BPW'(b);

    for (genvar k = 0; k < L; k++)
    begin : g_stage
        logic [AW-1:0]  a_in;
        logic [BPW-1:0] b_in;
        logic [PW-1:0]  acc_in;
        logic [PPW-1:0] pp;

        if (k == 0)
        begin : g_first
            assign a_in   = a;
            assign b_in   = b_pad;
            assign acc_in = '0;
        end
        else
        begin : g_next
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        assign pp = a_in * b_in[k*CW +: CW];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k] <= acc_in + (PW'(pp) << (k * CW));
            end
        end

        if (k < L - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[k] <= a_in;
                    b_reg[k] <= b_in;
                end
            end
        end
    end

    assign p = acc_reg[L-1];

endmodule

`default_nettype wire

FILE: rtl/core/gfc_isqrt.sv
// ----------------------------------------------------------------------------
// gfc_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_isqrt #(
    parameter int XW = 82
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [XW-1:0]   x,
    output logic      [XW/2-1:0] root
);

    localparam int RW  = XW / 2;
    localparam int RMW = RW + 2;

    logic [RMW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [XW-1:0]  x_reg    [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [RMW-1:0] rem_in;
        logic [RW-1:0]  root_in;
        logic [XW-1:0]  x_in;
        logic [RMW-1:0] r2;
        logic [RMW-1:0] trial;
        logic           take;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = x;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign x_in    = x_reg[i-1];
        end

        assign r2    = {rem_in[RMW-3:0], x_in[XW-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign take  = (r2 >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[i] <= {root_in[RW-2:0], take};
            end
        end

        if (i < RW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= take ? (r2 - trial) : r2;
                    x_reg[i]   <= x_in << 2;
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

`default_nettype wire

FILE: rtl/core/gfc_div.sv
// ----------------------------------------------------------------------------
// gfc_div
// Pipelined restoring divider: pre-shift, range check, one quotient bit
// per stage. Flags a quotient that does not fit OUT_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_div #(
    parameter int NW = 200,
    parameter int DW = 123
) (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [NW-1:0]                   num,
    input  wire logic [DW-1:0]                   den,
    input  wire logic [gfc_pkg::SHIFT_BITS-1:0]  sh,
    output logic      [gfc_pkg::OUT_BITS-1:0]    quo,
    output logic                                 ovf
);

    localparam int QW   = gfc_pkg::OUT_BITS;
    localparam int HW   = NW - QW;
    localparam int CMPW = (HW > DW) ? HW : DW;

    logic [NW-1:0] n0_reg;
    logic [DW-1:0] d0_reg;

    logic [DW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] lq_reg  [QW+1];
    logic          ovf_reg [QW+1];

    logic [HW-1:0] hi;

    assign hi = n0_reg[NW-1:QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg     <= num >> sh;
            d0_reg     <= den;
            ovf_reg[0] <= (CMPW'(hi) >= CMPW'(d0_reg));
            rem_reg[0] <= DW'(hi);
            den_reg[0] <= d0_reg;
            lq_reg[0]  <= n0_reg[QW-1:0];
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        logic [DW:0] r2;
        logic        take;

        assign r2   = {rem_reg[j-1], lq_reg[j-1][QW-1]};
        assign take = (r2 >= {1'b0, den_reg[j-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lq_reg[j]  <= {lq_reg[j-1][QW-2:0], take};
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end

        if (j < QW)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= take ? DW'(r2 - {1'b0, den_reg[j-1]}) : DW'(r2);
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign quo = lq_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

`default_nettype wire

FILE: rtl/core/pairwise_gravity_force_2d_top.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_force_2d_top
// Fixed-point 2D gravitational force on the first of two point masses.
//
//   channel | handshake               | beat
//   --------+-------------------------+----------------------------------------
//   in      | in_valid / in_stall     | first_x/y, second_x/y, masses
//   out     | out_valid / out_stall   | force_x, force_y, coincident, saturated
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled. The square
// root gives RT = COORD_BITS + 17 root bits. The whole pipe advances
// together; it holds only while a result sits in the output register under
// out_stall.
// Reset clears valid bits and config (gain 1, shift 0).
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_gravity_force_2d_top #(
    parameter int COORD_BITS = 24,
    parameter int MASS_BITS  = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [COORD_BITS-1:0]        first_x,
    input  wire logic signed [COORD_BITS-1:0]        first_y,
    input  wire logic signed [COORD_BITS-1:0]        second_x,
    input  wire logic signed [COORD_BITS-1:0]        second_y,
    input  wire logic        [MASS_BITS-1:0]         first_mass,
    input  wire logic        [MASS_BITS-1:0]         second_mass,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [gfc_pkg::OUT_BITS-1:0]      force_x,
    output logic signed [gfc_pkg::OUT_BITS-1:0]      force_y,
    output logic                                     coincident,
    output logic                                     saturated,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gfc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [gfc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int CW     = gfc_pkg::CHUNK_BITS;
    localparam int OW     = gfc_pkg::OUT_BITS;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int X_W    = SQ_W + 2 * gfc_pkg::SQRT_FRAC_BITS;
    localparam int RT_W   = X_W / 2;
    localparam int RQ2_W  = 2 * RT_W;
    localparam int DEN_W  = 3 * RT_W;
    localparam int GM_W   = gfc_pkg::GAIN_BITS + MASS_BITS;
    localparam int BASE_W = GM_W + MASS_BITS;
    localparam int NUM_W  = BASE_W + DIFF_W;
    localparam int DIVN_W = NUM_W + OW;
    localparam int LR     = (RT_W + CW - 1) / CW;
    localparam int LM     = (MASS_BITS + CW - 1) / CW;
    localparam int LD     = (DIFF_W + CW - 1) / CW;
    localparam int T_DEN  = 3 + RT_W + 2 * LR;
    localparam int ND     = T_DEN - (1 + LM + LD);
    localparam int SIDE_D = T_DEN + OW + 2;
    localparam int SIDE_W = $bits(gfc_pkg::side_t);

    // config
    logic [gfc_pkg::GAIN_BITS-1:0]  gain_reg;
    logic [gfc_pkg::SHIFT_BITS-1:0] shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= gfc_pkg::GAIN_RESET;
            shift_reg <= gfc_pkg::SHIFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gfc_pkg::cfg_reg_t'(cfg_index))
                gfc_pkg::REG_GAIN:  gain_reg  <= cfg_data[gfc_pkg::GAIN_BITS-1:0];
                gfc_pkg::REG_SHIFT: shift_reg <= cfg_data[gfc_pkg::SHIFT_BITS-1:0];
                default:            gain_reg  <= gain_reg;
            endcase
        end
    end

    // pipe advance
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // stage 1: differences, magnitudes, gain*m1
    logic [DIFF_W-1:0] dx_next, dy_next;
    logic [DIFF_W-1:0] ax_next, ay_next;
    logic [GM_W-1:0]   gm_next;
    gfc_pkg::side_t    side_next;

    assign dx_next = {second_x[COORD_BITS-1], second_x} - {first_x[COORD_BITS-1], first_x};
    assign dy_next = {second_y[COORD_BITS-1], second_y} - {first_y[COORD_BITS-1], first_y};
    assign ax_next = dx_next[DIFF_W-1] ? (DIFF_W'(0) - dx_next) : dx_next;
    assign ay_next = dy_next[DIFF_W-1] ? (DIFF_W'(0) - dy_next) : dy_next;
    assign gm_next = gain_reg * first_mass;

    assign side_next.vld   = in_valid;
    assign side_next.neg_x = dx_next[DIFF_W-1];
    assign side_next.neg_y = dy_next[DIFF_W-1];
    assign side_next.coinc = (first_x == second_x) && (first_y == second_y);

    logic [DIFF_W-1:0]    ax1_reg, ay1_reg;
    logic [GM_W-1:0]      gm1_reg;
    logic [MASS_BITS-1:0] m2_1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax1_reg  <= ax_next;
            ay1_reg  <= ay_next;
            gm1_reg  <= gm_next;
            m2_1_reg <= second_mass;
        end
    end

    gfc_pkg::side_t side_out;

    gfc_delay #(.WIDTH(SIDE_W), .DEPTH(SIDE_D)) u_side_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (side_next),
        .q     (side_out)
    );

    // stages 2-3: squared distance
    logic [SQ_W-1:0] sqx2_reg, sqy2_reg, s3_reg;
    logic [SQ_W-1:0] sqx_next, sqy_next;

    assign sqx_next = ax1_reg * ax1_reg;
    assign sqy_next = ay1_reg * ay1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx2_reg <= sqx_next;
            sqy2_reg <= sqy_next;
            s3_reg   <= sqx2_reg + sqy2_reg;
        end
    end

    // r in Q.16
    logic [RT_W-1:0] rq;

    gfc_isqrt #(.XW(X_W)) u_isqrt (
        .clk  (clk),
        .en   (adv),
        .x    ({s3_reg, {(2 * gfc_pkg::SQRT_FRAC_BITS){1'b0}}}),
        .root (rq)
    );

    // r^3
    logic [RQ2_W-1:0] rq2;
    logic [RT_W-1:0]  rq_d;
    logic [DEN_W-1:0] den;

    gfc_mul #(.AW(RT_W), .BW(RT_W)) u_mul_r2 (
        .clk (clk),
        .en  (adv),
        .a   (rq),
        .b   (rq),
        .p   (rq2)
    );

    gfc_delay #(.WIDTH(RT_W), .DEPTH(LR)) u_rq_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (rq),
        .q     (rq_d)
    );

    gfc_mul #(.AW(RQ2_W), .BW(RT_W)) u_mul_r3 (
        .clk (clk),
        .en  (adv),
        .a   (rq2),
        .b   (rq_d),
        .p   (den)
    );

    // gain*m1*m2*|d|
    logic [BASE_W-1:0]   base;
    logic [DIFF_W-1:0]   ax_d, ay_d;
    logic [NUM_W-1:0]    numx, numy;
    logic [NUM_W-1:0]    numx_d, numy_d;

    gfc_mul #(.AW(GM_W), .BW(MASS_BITS)) u_mul_base (
        .clk (clk),
        .en  (adv),
        .a   (gm1_reg),
        .b   (m2_1_reg),
        .p   (base)
    );

    gfc_delay #(.WIDTH(2 * DIFF_W), .DEPTH(LM)) u_dist_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     ({ax1_reg, ay1_reg}),
        .q     ({ax_d, ay_d})
    );

    gfc_mul #(.AW(BASE_W), .BW(DIFF_W)) u_mul_nx (
        .clk (clk),
        .en  (adv),
        .a   (base),
        .b   (ax_d),
        .p   (numx)
    );

    gfc_mul #(.AW(BASE_W), .BW(DIFF_W)) u_mul_ny (
        .clk (clk),
        .en  (adv),
        .a   (base),
        .b   (ay_d),
        .p   (numy)
    );

    gfc_delay #(.WIDTH(2 * NUM_W), .DEPTH(ND)) u_num_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     ({numx, numy}),
        .q     ({numx_d, numy_d})
    );

    // quotients
    logic [OW-1:0] qx, qy;
    logic          ovfx, ovfy;

    gfc_div #(.NW(DIVN_W), .DW(DEN_W)) u_div_x (
        .clk (clk),
        .en  (adv),
        .num ({numx_d, {OW{1'b0}}}),
        .den (den),
        .sh  (shift_reg),
        .quo (qx),
        .ovf (ovfx)
    );

    gfc_div #(.NW(DIVN_W), .DW(DEN_W)) u_div_y (
        .clk (clk),
        .en  (adv),
        .num ({numy_d, {OW{1'b0}}}),
        .den (den),
        .sh  (shift_reg),
        .quo (qy),
        .ovf (ovfy)
    );

    // clamp, sign, output register
    logic [OW-1:0] limx, limy, magx, magy;
    logic          satx, saty;

    assign limx = side_out.neg_x ? gfc_pkg::OUT_MAX_NEG : gfc_pkg::OUT_MAX_POS;
    assign limy = side_out.neg_y ? gfc_pkg::OUT_MAX_NEG : gfc_pkg::OUT_MAX_POS;
    assign satx = ovfx || (qx > limx);
    assign saty = ovfy || (qy > limy);
    assign magx = satx ? limx : qx;
    assign magy = saty ? limy : qy;

    logic [OW-1:0] fx_reg, fy_reg;
    logic          coinc_reg, sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= side_out.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (side_out.coinc)
            begin
                fx_reg    <= '0;
                fy_reg    <= '0;
                coinc_reg <= 1'b1;
                sat_reg   <= 1'b0;
            end
            else
            begin
                fx_reg    <= side_out.neg_x ? (OW'(0) - magx) : magx;
                fy_reg    <= side_out.neg_y ? (OW'(0) - magy) : magy;
                coinc_reg <= 1'b0;
                sat_reg   <= satx || saty;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign force_x    = fx_reg;
    assign force_y    = fy_reg;
    assign coincident = coinc_reg;
    assign saturated  = sat_reg;

endmodule

`default_nettype wire

FILE: rtl/core/gfc_chk.sv
// ----------------------------------------------------------------------------
// gfc_chk
// Port-level checks for the gravity force pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_chk (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   in_stall,
    input wire logic                                   out_valid,
    input wire logic                                   out_stall,
    input wire logic signed [gfc_pkg::OUT_BITS-1:0]    force_x,
    input wire logic signed [gfc_pkg::OUT_BITS-1:0]    force_y,
    input wire logic                                   coincident,
    input wire logic                                   saturated
);

    localparam logic [gfc_pkg::OUT_BITS-1:0] MAXP = gfc_pkg::OUT_MAX_POS;
    localparam logic [gfc_pkg::OUT_BITS-1:0] MAXN = gfc_pkg::OUT_MAX_NEG;

    a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && coincident |-> force_x == '0 && force_y == '0 && !saturated)
        else $error("coincident beat with nonzero force or saturation");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            force_x == MAXP || force_x == MAXN || force_y == MAXP || force_y == MAXN)
        else $error("saturated beat with no component at a bound");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(force_x) && $stable(force_y))
        else $error("stalled output beat changed");

endmodule

bind pairwise_gravity_force_2d_top gfc_chk u_gfc_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .force_x    (force_x),
    .force_y    (force_y),
    .coincident (coincident),
    .saturated  (saturated)
);

`default_nettype wire

FILE: verif/pairwise_gravity_force_2d_top_tb.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_force_2d_top_tb
// Streams body pairs through the gravity force pipeline under several gain and
// shift settings and idle patterns. Every output beat is checked against a
// wide-integer force predictor run on each accepted input beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pairwise_gravity_force_2d_top_tb;

    typedef struct {
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic [23:0]        m1;
        logic [23:0]        m2;
    } body_pair_t;

    typedef struct {
        logic [gfc_pkg::OUT_BITS-1:0] fx;
        logic [gfc_pkg::OUT_BITS-1:0] fy;
        logic                         coinc;
        logic                         sat;
    } force_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [23:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
    logic [23:0] first_mass = '0, second_mass = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [gfc_pkg::OUT_BITS-1:0] force_x, force_y;
    logic coincident, saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [gfc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [gfc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    body_pair_t pending_pairs[$];
    force_t     expected_forces[$];
    body_pair_t cur_pair;
    logic [31:0] gain_r = 32'd1;
    logic [5:0]  shift_r = 6'd0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    logic hold_kick = 1'b0;
    int mismatches = 0;

    pairwise_gravity_force_2d_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
        .first_mass(first_mass), .second_mass(second_mass),
        .out_valid(out_valid), .out_stall(out_stall),
        .force_x(force_x), .force_y(force_y),
        .coincident(coincident), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [48:0] axis_force(longint d, logic [255:0] base,
                                               logic [255:0] den);
        logic [255:0] num;
        logic [255:0] q;
        logic [63:0]  mag;
        logic [63:0]  lim;
        logic         neg;
        neg = d < 0;
        mag = neg ? 64'(-d) : 64'(d);
        lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 64'd1);
        num = (base * 256'(mag)) << 48;
        q = (num / den) >> shift_r;
        if (q[255:64] != '0 || q[63:0] > lim)
            return {1'b1, neg ? -lim[47:0] : lim[47:0]};
        return {1'b0, neg ? -q[47:0] : q[47:0]};
    endfunction

    function automatic force_t gravity_force(body_pair_t p);
        force_t r;
        longint dx, dy;
        logic [255:0] s, t, rq, den, base;
        logic [48:0] cx, cy;
        dx = longint'(p.sx) - longint'(p.fx);
        dy = longint'(p.sy) - longint'(p.fy);
        if (dx == 0 && dy == 0)
        begin
            r.fx = '0;
            r.fy = '0;
            r.coinc = 1'b1;
            r.sat = 1'b0;
            return r;
        end
        s = (256'(dx * dx) + 256'(dy * dy)) << 32;
        rq = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = rq | (256'd1 << b);
            if (t * t <= s)
                rq = t;
        end
        den = rq * rq * rq;
        base = 256'(gain_r) * 256'(p.m1) * 256'(p.m2);
        cx = axis_force(dx, base, den);
        cy = axis_force(dy, base, den);
        r.fx = cx[47:0];
        r.fy = cy[47:0];
        r.coinc = 1'b0;
        r.sat = cx[48] | cy[48];
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_forces.push_back(gravity_force(cur_pair));
            if (!in_valid || !in_stall)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_pair = pending_pairs.pop_front();
                    in_valid <= 1'b1;
                    first_x <= cur_pair.fx;
                    first_y <= cur_pair.fy;
                    second_x <= cur_pair.sx;
                    second_y <= cur_pair.sy;
                    first_mass <= cur_pair.m1;
                    second_mass <= cur_pair.m2;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_kick)
            hold_left <= 400;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        force_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_forces.size() == 0)
                begin
                    $error("output beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    e = expected_forces.pop_front();
                    if (force_x !== e.fx)
                    begin
                        $error("force_x exp %0d got %0d", $signed(e.fx), force_x);
                        mismatches++;
                    end
                    if (force_y !== e.fy)
                    begin
                        $error("force_y exp %0d got %0d", $signed(e.fy), force_y);
                        mismatches++;
                    end
                    if (coincident !== e.coinc)
                    begin
                        $error("coincident exp %0b got %0b", e.coinc, coincident);
                        mismatches++;
                    end
                    if (saturated !== e.sat)
                    begin
                        $error("saturated exp %0b got %0b", e.sat, saturated);
                        mismatches++;
                    end
                end
            end
            out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_reg(gfc_pkg::cfg_reg_t idx, logic [31:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == gfc_pkg::REG_GAIN)
            gain_r = v;
        else
            shift_r = v[5:0];
    endtask

    task automatic drain();
        do @(negedge clk);
        while (pending_pairs.size() > 0 || in_valid || expected_forces.size() > 0);
    endtask

    function automatic body_pair_t mk_pair(int fx, int fy, int sx, int sy, int m1, int m2);
        body_pair_t p;
        p.fx = fx[23:0];
        p.fy = fy[23:0];
        p.sx = sx[23:0];
        p.sy = sy[23:0];
        p.m1 = m1[23:0];
        p.m2 = m2[23:0];
        return p;
    endfunction

    function automatic body_pair_t rand_pair();
        body_pair_t p;
        p.fx = 24'($urandom);
        p.fy = 24'($urandom);
        p.m1 = 24'($urandom);
        p.m2 = 24'($urandom);
        case ($urandom_range(7))
            0, 1, 2:
            begin
                p.sx = 24'($urandom);
                p.sy = 24'($urandom);
            end
            3, 4, 5:
            begin
                p.sx = p.fx + 24'($urandom_range(2000)) - 24'd1000;
                p.sy = p.fy + 24'($urandom_range(2000)) - 24'd1000;
            end
            6:
            begin
                p.sx = p.fx + 24'($urandom_range(6)) - 24'd3;
                p.sy = p.fy;
                p.m1 = 24'($urandom_range(255));
            end
            default:
            begin
                p.sx = p.fx;
                p.sy = p.fy;
            end
        endcase
        return p;
    endfunction

    task automatic run_phase(logic [31:0] g, logic [5:0] sh, int sp, int rp, int n,
                             bit hold, bit pause);
        write_reg(gfc_pkg::REG_GAIN, g);
        write_reg(gfc_pkg::REG_SHIFT, {26'd0, sh});
        send_idle_pct = sp;
        recv_stall_pct = rp;
        if (hold)
        begin
            hold_kick <= 1'b1;
            @(posedge clk);
            hold_kick <= 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            pending_pairs.push_back(rand_pair());
            if (pause && i == n / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        int mx, mn, mm;
        mx = 8388607;
        mn = -8388608;
        mm = 16777215;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        pending_pairs.push_back(mk_pair(0, 0, 0, 0, mm, mm));
        pending_pairs.push_back(mk_pair(mn, mn, mn, mn, 5, 7));
        pending_pairs.push_back(mk_pair(0, 0, 1, 0, mm, mm));
        pending_pairs.push_back(mk_pair(0, 0, -1, 0, mm, mm));
        pending_pairs.push_back(mk_pair(0, 0, 0, 1, mm, mm));
        pending_pairs.push_back(mk_pair(0, 0, 0, -1, mm, mm));
        pending_pairs.push_back(mk_pair(mn, mn, mx, mx, mm, mm));
        pending_pairs.push_back(mk_pair(mx, mx, mn, mn, mm, mm));
        pending_pairs.push_back(mk_pair(mn, 0, mx, 0, mm, mm));
        pending_pairs.push_back(mk_pair(0, mx, 0, mn, mm, mm));
        pending_pairs.push_back(mk_pair(0, 0, 3, 4, 0, mm));
        pending_pairs.push_back(mk_pair(0, 0, 3, 4, mm, 0));
        pending_pairs.push_back(mk_pair(10, 20, 13, 24, 1000, 2000));
        pending_pairs.push_back(mk_pair(-5, 7, -8, 3, 4096, 4096));
        pending_pairs.push_back(mk_pair(100, 100, 101, 101, 65535, 65535));
        pending_pairs.push_back(mk_pair(0, 0, 1000, -1000, mm, 1));
        drain();
        pending_pairs.push_back(mk_pair(0, 0, 0, 0, 1, 1));
        pending_pairs.push_back(mk_pair(0, 0, 1, 1, mm, mm));
        pending_pairs.push_back(mk_pair(mn, mn, mx, mx, mm, mm));
        drain();
        run_phase(32'hFFFF_FFFF, 6'd63, 0, 0, 150, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFFF, 6'd0, 0, 0, 100, 1'b0, 1'b0);
        run_phase($urandom, 6'd20, 73, 0, 200, 1'b0, 1'b0);
        run_phase(32'd1000, 6'd0, 0, 73, 200, 1'b1, 1'b0);
        run_phase(32'd0, 6'd5, 6, 6, 80, 1'b0, 1'b0);
        run_phase($urandom, 6'($urandom_range(63)), 73, 73, 120, 1'b0, 1'b0);
        run_phase($urandom, 6'($urandom_range(40)), 0, 0, 350, 1'b1, 1'b1);
        repeat (120) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/gfc_pkg.sv
rtl/core/gfc_delay.sv
rtl/core/gfc_mul.sv
rtl/core/gfc_isqrt.sv
rtl/core/gfc_div.sv
rtl/core/pairwise_gravity_force_2d_top.sv
rtl/core/gfc_chk.sv
verif/pairwise_gravity_force_2d_top_tb.sv
